// File: rtl/nsc_pkg.sv
package nsc_pkg;

	localparam int LINE_LIMIT  = 63;
	localparam int FIELD_LIMIT = 12;
	localparam int QUEUE_DEPTH = 4;

	localparam int LINE_AW = $clog2(LINE_LIMIT);
	localparam int LINE_CW = $clog2(LINE_LIMIT + 1);
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	// Field buffer holds up to twelve characters, character 0 in the lowest byte
	localparam int FBUF_W = 96;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_A      = 8'h41;

	localparam logic [1:0] EV_SUM_ERR = 2'd0;
	localparam logic [1:0] EV_SUM_OK  = 2'd1;
	localparam logic [1:0] EV_FIELD   = 2'd2;

	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_GSA  = 3'd1;
	localparam logic [2:0] ST_GGA  = 3'd2;
	localparam logic [2:0] ST_RMC  = 3'd3;
	localparam logic [2:0] ST_GLL  = 3'd4;
	localparam logic [2:0] ST_VTG  = 3'd5;
	localparam logic [2:0] ST_GSV  = 3'd6;

	// Sentence names packed with the first character in the lowest byte
	localparam logic [47:0] NAME_GSA = 48'h41_53_47_50_47_24;
	localparam logic [47:0] NAME_GGA = 48'h41_47_47_50_47_24;
	localparam logic [47:0] NAME_RMC = 48'h43_4D_52_50_47_24;
	localparam logic [47:0] NAME_GLL = 48'h4C_4C_47_50_47_24;
	localparam logic [47:0] NAME_VTG = 48'h47_54_56_50_47_24;
	localparam logic [47:0] NAME_GSV = 48'h56_53_47_50_47_24;

	// Command passed from the byte front end to the line walker
	typedef struct packed {
		logic               is_end;
		logic [7:0]         data;
		logic [LINE_AW-1:0] addr;
		logic [LINE_CW-1:0] seps;
		logic               sum_ok;
	} cmd_t;

	function automatic logic [2:0] sentence_type(input logic [47:0] head);
		logic [2:0] kind;
		kind = ST_NONE;
		if (head == NAME_GSA) kind = ST_GSA;
		else if (head == NAME_GGA) kind = ST_GGA;
		else if (head == NAME_RMC) kind = ST_RMC;
		else if (head == NAME_GLL) kind = ST_GLL;
		else if (head == NAME_VTG) kind = ST_VTG;
		else if (head == NAME_GSV) kind = ST_GSV;
		return kind;
	endfunction

	function automatic logic is_separator(input logic [7:0] c);
		return (c == CH_COMMA) || (c == CH_STAR);
	endfunction

endpackage

// File: rtl/nsc_queue.sv
module nsc_queue import nsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	assign full     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/nsc_front.sv
module nsc_front import nsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       cmd_push,
	output cmd_t       cmd_data,
	input  logic       cmd_full
);

	logic [7:0]         running_xor_q;
	logic [7:0]         reported_sum_q;
	logic [1:0]         sum_phase_q;
	logic [LINE_CW-1:0] line_count_q;
	logic [LINE_CW-1:0] sep_count_q;

	logic       accept;
	logic       is_lf;
	logic       is_cr;
	logic       room;
	logic [7:0] digit;
	logic [1:0] phase_mid;

	assign in_stall = cmd_full;
	assign accept   = in_valid && !cmd_full;
	assign is_lf    = (rx_byte == CH_LF);
	assign is_cr    = (rx_byte == CH_CR);
	assign room     = (line_count_q < LINE_CW'(LINE_LIMIT));

	// Uppercase-only hex conversion, wrapping modulo 256
	assign digit     = (rx_byte >= CH_A) ? (rx_byte - CH_A + 8'd10) : (rx_byte - CH_ZERO);
	assign phase_mid = (rx_byte == CH_STAR) ? 2'd2 : sum_phase_q;

	always_comb begin
		cmd_push        = 1'b0;
		cmd_data.is_end = is_cr;
		cmd_data.data   = rx_byte;
		cmd_data.addr   = line_count_q[LINE_AW-1:0];
		cmd_data.seps   = sep_count_q;
		cmd_data.sum_ok = (running_xor_q == reported_sum_q);
		if (accept && !is_lf) begin
			if (is_cr) begin
				cmd_push = (line_count_q != '0);
			end else begin
				cmd_push = room;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_xor_q  <= '0;
			reported_sum_q <= '0;
			sum_phase_q    <= '0;
			line_count_q   <= '0;
			sep_count_q    <= '0;
		end else if (accept && !is_lf) begin
			if (is_cr) begin
				running_xor_q  <= '0;
				reported_sum_q <= '0;
				sum_phase_q    <= '0;
				line_count_q   <= '0;
				sep_count_q    <= '0;
			end else begin
				if (sum_phase_q == 2'd2) begin
					reported_sum_q <= {reported_sum_q[3:0], 4'b0000} | digit;
				end
				if (phase_mid == 2'd1) begin
					running_xor_q <= running_xor_q ^ rx_byte;
				end
				sum_phase_q <= (rx_byte == CH_DOLLAR) ? 2'd1 : phase_mid;
				if (room) begin
					line_count_q <= line_count_q + 1'b1;
					if (is_separator(rx_byte)) begin
						sep_count_q <= sep_count_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

// File: rtl/nsc_back.sv
module nsc_back import nsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_empty,
	input  cmd_t        cmd_data,
	output logic        cmd_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [2:0]  sentence_kind,
	output logic [5:0]  field_number,
	output logic [3:0]  field_length,
	output logic [63:0] chars_first_eight,
	output logic [31:0] chars_last_four,
	output logic        last_of_line
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_PROC
	} state_t;

	logic [7:0]         line_mem [LINE_LIMIT];
	logic [7:0]         rd_data_q;

	state_t             state_q;
	logic [LINE_AW-1:0] ptr_q;
	logic [LINE_CW-1:0] seps_q;
	logic [LINE_CW-1:0] field_no_q;
	logic [3:0]         flen_q;
	logic [FBUF_W-1:0]  fbuf_q;
	logic [2:0]         sent_q;

	logic               out_valid_q;
	logic [1:0]         event_q;
	logic [2:0]         sentence_q;
	logic [5:0]         number_q;
	logic [3:0]         length_q;
	logic [FBUF_W-1:0]  chars_q;
	logic               last_q;

	logic out_free;
	logic mem_we;
	logic last_field;

	assign out_free   = !out_valid_q || !out_stall;
	assign mem_we     = (state_q == S_IDLE) && !cmd_empty && !cmd_data.is_end;
	assign last_field = ((field_no_q + 1'b1) == seps_q);

	always_comb begin
		cmd_pop = 1'b0;
		if (state_q == S_IDLE && !cmd_empty) begin
			cmd_pop = !cmd_data.is_end || out_free;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[cmd_data.addr] <= cmd_data.data;
		end
		rd_data_q <= line_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			seps_q      <= '0;
			field_no_q  <= '0;
			flen_q      <= '0;
			fbuf_q      <= '0;
			sent_q      <= ST_NONE;
			out_valid_q <= 1'b0;
			event_q     <= EV_SUM_ERR;
			sentence_q  <= ST_NONE;
			number_q    <= '0;
			length_q    <= '0;
			chars_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!cmd_empty && cmd_data.is_end && out_free) begin
						out_valid_q <= 1'b1;
						event_q     <= cmd_data.sum_ok ? EV_SUM_OK : EV_SUM_ERR;
						sentence_q  <= ST_NONE;
						number_q    <= '0;
						length_q    <= '0;
						chars_q     <= '0;
						last_q      <= !cmd_data.sum_ok || (cmd_data.seps < LINE_CW'(2));
						ptr_q       <= '0;
						seps_q      <= cmd_data.seps;
						field_no_q  <= '0;
						flen_q      <= '0;
						fbuf_q      <= '0;
						sent_q      <= ST_NONE;
						if (cmd_data.sum_ok && cmd_data.seps >= LINE_CW'(2)) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_PROC;
				end
				S_PROC: begin
					if (is_separator(rd_data_q)) begin
						if (field_no_q == '0) begin
							if (flen_q >= 4'd6) begin
								sent_q <= sentence_type(fbuf_q[47:0]);
							end
							field_no_q <= field_no_q + 1'b1;
							flen_q     <= '0;
							fbuf_q     <= '0;
							ptr_q      <= ptr_q + 1'b1;
							state_q    <= S_READ;
						end else if (out_free) begin
							out_valid_q <= 1'b1;
							event_q     <= EV_FIELD;
							sentence_q  <= sent_q;
							number_q    <= 6'(field_no_q);
							length_q    <= flen_q;
							chars_q     <= fbuf_q;
							last_q      <= last_field;
							field_no_q  <= field_no_q + 1'b1;
							flen_q      <= '0;
							fbuf_q      <= '0;
							ptr_q       <= ptr_q + 1'b1;
							// Text after the final separator forms no field
							state_q     <= last_field ? S_IDLE : S_READ;
						end
					end else begin
						if (flen_q < 4'(FIELD_LIMIT)) begin
							fbuf_q[flen_q*8 +: 8] <= rd_data_q;
							flen_q                <= flen_q + 1'b1;
						end
						ptr_q   <= ptr_q + 1'b1;
						state_q <= S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign event_kind        = event_q;
	assign sentence_kind     = sentence_q;
	assign field_number      = number_q;
	assign field_length      = length_q;
	assign chars_first_eight = chars_q[63:0];
	assign chars_last_four   = chars_q[95:64];
	assign last_of_line      = last_q;

endmodule

// File: rtl/nmea_sentence_checker_splitter.sv
// Flow: a CR that finds the queue empty and the walker idle gives its status through the queue
//   and output registers; with a good checksum, one field result per separator after the first.
// Throughput: one byte per cycle while the four-entry queue has room; a CR walk reads each
//   stored character from the registered line memory, then processes it.
// Reset: arst_n clears checksum, counts, queue and output valid at once; line memory is
//   not cleared, since only entries written since the last CR are ever read.
module nmea_sentence_checker_splitter import nsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [2:0]  sentence_kind,
	output logic [5:0]  field_number,
	output logic [3:0]  field_length,
	output logic [63:0] chars_first_eight,
	output logic [31:0] chars_last_four,
	output logic        last_of_line
);

	// Front end: run the checksum and turn each stored byte or closing CR into a store or end-of-line transaction
	cmd_t push_data;
	cmd_t pop_data;
	logic push;
	logic pop;
	logic full;
	logic empty;

	nsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.cmd_push (push),
		.cmd_data (push_data),
		.cmd_full (full)
	);

	// Short queue: decouple byte intake from the line walk
	nsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// Back end: hold the line, report status and split fields into the output register
	nsc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_empty         (empty),
		.cmd_data          (pop_data),
		.cmd_pop           (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.event_kind        (event_kind),
		.sentence_kind     (sentence_kind),
		.field_number      (field_number),
		.field_length      (field_length),
		.chars_first_eight (chars_first_eight),
		.chars_last_four   (chars_last_four),
		.last_of_line      (last_of_line)
	);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top import nsc_pkg::*; ();

	// Generous cycle budget: lines of up to 63 stored characters walked one by
	// one, up to 63 results per line, every one of them under heavy stall.
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_BYTES  = 100;
	localparam int DRAIN_CYCLES  = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  event_kind;
	logic [2:0]  sentence_kind;
	logic [5:0]  field_number;
	logic [3:0]  field_length;
	logic [63:0] chars_first_eight;
	logic [31:0] chars_last_four;
	logic        last_of_line;

	nmea_sentence_checker_splitter i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.event_kind        (event_kind),
		.sentence_kind     (sentence_kind),
		.field_number      (field_number),
		.field_length      (field_length),
		.chars_first_eight (chars_first_eight),
		.chars_last_four   (chars_last_four),
		.last_of_line      (last_of_line)
	);

	// One result transaction as it leaves the block
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  sentence;
		logic [5:0]  number;
		logic [3:0]  length;
		logic [63:0] first_eight;
		logic [31:0] last_four;
		logic        last;
	} nmea_result_t;

	// Checksum span of the sentence being received
	typedef enum logic [1:0] {
		SPAN_OUTSIDE = 2'd0,
		SPAN_INSIDE  = 2'd1,
		SPAN_DIGITS  = 2'd2
	} span_state_e;

	// How the results of a carriage return are checked: by the parser model, or
	// against a result typed into the stimulus table
	typedef enum {
		BY_PARSER,
		WANT_NOTHING,
		WANT_SUM_ERR,
		WANT_SUM_OK_ONLY
	} cr_check_e;

	typedef struct {
		string     text;
		int        nul_at;
		bit        sealed;
		cr_check_e check;
	} stim_row_t;

	string      sentence_tags[6]  = '{"$GPGSA", "$GPGGA", "$GPRMC",
		"$GPGLL", "$GPVTG", "$GPGSV"};
	logic [2:0] sentence_codes[6] = '{ST_GSA, ST_GGA, ST_RMC, ST_GLL, ST_VTG, ST_GSV};

	// Directed lines. Unsealed rows carry their own CR; sealed rows get a correct
	// "*HH" checksum and CR appended. nul_at replaces one character with a zero byte.
	stim_row_t stim_table[$] = '{
		'{"\r",                           -1, 1'b0, WANT_NOTHING},
		'{"\n\r",                         -1, 1'b0, WANT_NOTHING},
		'{"ABC\r",                        -1, 1'b0, WANT_SUM_OK_ONLY},
		'{"\377\r",                       -1, 1'b0, WANT_SUM_OK_ONLY},
		'{"Z\r",                           0, 1'b0, WANT_SUM_OK_ONLY},
		'{"$A*41\r",                      -1, 1'b0, WANT_SUM_OK_ONLY},
		'{"$GPGGA,1*00\r",                -1, 1'b0, WANT_SUM_ERR},
		'{"$GPGSA,A,3,04,05",             -1, 1'b1, BY_PARSER},
		'{"$GPGGA,123519,4807.038,N",     -1, 1'b1, BY_PARSER},
		'{"$GPRMC,X,,Y",                  -1, 1'b1, BY_PARSER},
		'{"$GPGLL,AxB,C",                  8, 1'b1, BY_PARSER},
		'{"$GPVTG,0123456789ABCDEF,Z",    -1, 1'b1, BY_PARSER},
		'{"$GPGSV,1\n,2",                 -1, 1'b1, BY_PARSER},
		'{"$GPGSAX,1",                    -1, 1'b1, BY_PARSER},
		'{"$GPGS,1",                      -1, 1'b1, BY_PARSER},
		'{"$gpgga,1",                     -1, 1'b1, BY_PARSER},
		'{"$A*a\r",                       -1, 1'b0, BY_PARSER},
		'{"$$A*#\r",                      -1, 1'b0, BY_PARSER},
		'{"$A*1$B*2\r",                   -1, 1'b0, BY_PARSER},
		'{"*Z\r",                         -1, 1'b0, BY_PARSER},
		'{"A,B\r",                        -1, 1'b0, BY_PARSER},
		'{{"$GPRMC,AAAAAAAAAA,BBBBBBBBBB,CCCCCCCCCC,DDDDDDDDDD,",
			"EEEEEEEEEE,FFFFFFFFFF,GG"},  -1, 1'b1, BY_PARSER}
	};

	// Parser model state
	logic [7:0]  line_xor;
	logic [7:0]  told_sum;
	span_state_e span_state;
	int          kept_len;
	logic [7:0]  kept_chars[LINE_LIMIT];

	nmea_result_t awaited_results[$];
	int           mismatch_count = 0;
	int           results_seen   = 0;
	int           bytes_taken    = 0;
	int           cycle_count    = 0;
	int           send_idle_pct;
	int           recv_stall_pct;

	// Clock: 20 ns period
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Watchdog: a stuck handshake or a lost result ends the run here
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t result %0d: %s", $realtime, results_seen, what);
		mismatch_count++;
	endtask

	// Split the stored line at ',' and '*'. Field 0 names the sentence; every
	// later field that is closed by a separator becomes one result.
	function automatic void split_fields(ref nmea_result_t res[$]);
		logic [7:0]   fld[FIELD_LIMIT];
		int           flen;
		int           fidx;
		logic [2:0]   sent;
		logic [7:0]   c;
		bit           hit;
		nmea_result_t r;
		flen = 0;
		fidx = 0;
		sent = ST_NONE;
		foreach (fld[j]) fld[j] = '0;
		for (int i = 0; i < kept_len; i++) begin
			c = kept_chars[i];
			if (c == CH_COMMA || c == CH_STAR) begin
				if (fidx == 0) begin
					// The type needs all six name characters, nothing shorter
					if (flen >= 6) begin
						for (int t = 0; t < 6; t++) begin
							hit = 1'b1;
							for (int j = 0; j < 6; j++)
								if (fld[j] != sentence_tags[t][j]) hit = 1'b0;
							if (hit) begin
								sent = sentence_codes[t];
								break;
							end
						end
					end
				end else if (res.size() < 63) begin
					r = '0;
					r.kind     = EV_FIELD;
					r.sentence = sent;
					r.number   = fidx[5:0];
					r.length   = flen[3:0];
					for (int j = 0; j < flen; j++) begin
						if (j < 8) r.first_eight[8*j +: 8] = fld[j];
						else r.last_four[8*(j-8) +: 8] = fld[j];
					end
					res.push_back(r);
				end
				fidx++;
				flen = 0;
				foreach (fld[j]) fld[j] = '0;
			end else if (flen < FIELD_LIMIT) begin
				fld[flen] = c;
				flen++;
			end
		end
	endfunction

	// Advance the parser model by one accepted byte and return the results it causes
	function automatic void parse_byte(input logic [7:0] c, ref nmea_result_t res[$]);
		nmea_result_t r;
		logic [7:0]   digit;
		res = {};
		if (c == CH_LF) return;
		if (c == CH_CR) begin
			if (kept_len > 0) begin
				r = '0;
				r.kind = (line_xor != told_sum) ? EV_SUM_ERR : EV_SUM_OK;
				res.push_back(r);
				if (r.kind == EV_SUM_OK) split_fields(res);
				r = res[res.size()-1];
				r.last = 1'b1;
				res[res.size()-1] = r;
			end
			line_xor   = '0;
			told_sum   = '0;
			span_state = SPAN_OUTSIDE;
			kept_len   = 0;
			return;
		end
		// Uppercase-only hex conversion; anything else wraps and is ORed in whole
		if (span_state == SPAN_DIGITS) begin
			digit    = (c >= CH_A) ? 8'(c - CH_A + 8'd10) : 8'(c - CH_ZERO);
			told_sum = {told_sum[3:0], 4'b0000} | digit;
		end
		if (c == CH_STAR) span_state = SPAN_DIGITS;
		if (span_state == SPAN_INSIDE) line_xor ^= c;
		if (c == CH_DOLLAR) span_state = SPAN_INSIDE;
		if (kept_len < LINE_LIMIT) begin
			kept_chars[kept_len] = c;
			kept_len++;
		end
	endfunction

	// Checksum over the span as a correct sender would compute it
	function automatic logic [7:0] span_xor(input logic [7:0] q[$]);
		logic [7:0] acc;
		bit         in_span;
		acc     = '0;
		in_span = 1'b0;
		foreach (q[i]) begin
			if (q[i] == CH_STAR) break;
			if (q[i] != CH_LF && in_span) acc ^= q[i];
			if (q[i] == CH_DOLLAR) in_span = 1'b1;
		end
		return acc;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 10) ? 8'(CH_ZERO + n) : 8'(CH_A + n - 10);
	endfunction

	// Close a sentence: '*', two hex digits, CR and sometimes a trailing LF
	task automatic seal_line(ref logic [7:0] q[$], input bit honest);
		logic [7:0] sum;
		sum = span_xor(q);
		if (!honest) sum ^= 8'($urandom_range(1, 255));
		q.push_back(CH_STAR);
		q.push_back(hex_char(sum[7:4]));
		q.push_back(hex_char(sum[3:0]));
		q.push_back(CH_CR);
		if ($urandom_range(1)) q.push_back(CH_LF);
	endtask

	// Field content: mostly printable, now and then any byte that is not a delimiter
	function automatic logic [7:0] random_text_char();
		logic [7:0] c;
		do begin
			c = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
		end while (c == CH_CR || c == CH_LF || c == CH_COMMA || c == CH_STAR || c == CH_DOLLAR);
		return c;
	endfunction

	// Drive one input transaction. Starts and ends at a falling edge; valid stays
	// high from one byte to the next unless an idle cycle is taken.
	task automatic put_byte(input logic [7:0] b, input cr_check_e check);
		nmea_result_t res[$];
		nmea_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			rx_byte  = 8'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte  = b;
		// Hold the payload until the block takes it
		@(posedge clk);
		while (in_stall) @(posedge clk);
		parse_byte(b, res);
		if (b != CH_LF) bytes_taken++;
		r = '0;
		r.last = 1'b1;
		if (b == CH_CR && check == WANT_SUM_ERR) begin
			r.kind = EV_SUM_ERR;
			awaited_results.push_back(r);
		end else if (b == CH_CR && check == WANT_SUM_OK_ONLY) begin
			r.kind = EV_SUM_OK;
			awaited_results.push_back(r);
		end else if (!(b == CH_CR && check == WANT_NOTHING)) begin
			foreach (res[i]) awaited_results.push_back(res[i]);
		end
		@(negedge clk);
	endtask

	// Random line: mostly well-formed sentences with random content, some with a
	// corrupted byte or a wrong checksum, some pure noise
	task automatic send_random_sentence();
		logic [7:0] q[$];
		int         shape;
		int         nfields;
		int         flen;
		string      tag;
		shape = $urandom_range(99);
		if (shape >= 85) begin
			repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(255)));
			q.push_back(CH_CR);
		end else begin
			q.push_back(CH_DOLLAR);
			if ($urandom_range(5) == 0) begin
				repeat ($urandom_range(2, 7)) q.push_back(random_text_char());
			end else begin
				tag = sentence_tags[$urandom_range(5)];
				for (int j = 1; j < 6; j++) q.push_back(tag[j]);
			end
			// Rare long lines overflow the line store
			nfields = ($urandom_range(9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
			repeat (nfields) begin
				q.push_back(CH_COMMA);
				flen = ($urandom_range(7) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 6);
				repeat (flen) q.push_back(random_text_char());
			end
			seal_line(q, $urandom_range(9) != 0);
			if (shape >= 70) q[$urandom_range(q.size() - 2)] = 8'($urandom_range(255));
		end
		foreach (q[i]) put_byte(q[i], BY_PARSER);
	endtask

	// Receiver stall, redrawn at every falling edge
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Check every accepted result transaction against the oldest awaited one
	always @(posedge clk) begin
		nmea_result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with nothing awaited");
			end else begin
				w = awaited_results.pop_front();
				if (event_kind !== w.kind)
					report_mismatch($sformatf("event_kind %0d, want %0d", event_kind, w.kind));
				if (sentence_kind !== w.sentence)
					report_mismatch($sformatf("sentence_kind %0d, want %0d",
						sentence_kind, w.sentence));
				if (field_number !== w.number)
					report_mismatch($sformatf("field_number %0d, want %0d",
						field_number, w.number));
				if (field_length !== w.length)
					report_mismatch($sformatf("field_length %0d, want %0d",
						field_length, w.length));
				if (chars_first_eight !== w.first_eight)
					report_mismatch($sformatf("chars_first_eight %h, want %h",
						chars_first_eight, w.first_eight));
				if (chars_last_four !== w.last_four)
					report_mismatch($sformatf("chars_last_four %h, want %h",
						chars_last_four, w.last_four));
				if (last_of_line !== w.last)
					report_mismatch($sformatf("last_of_line %0b, want %0b", last_of_line, w.last));
			end
			results_seen++;
		end
	end

	initial begin
		logic [7:0] row_bytes[$];
		string      commas;
		int         random_base;
		int         done;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		rx_byte        = '0;
		send_idle_pct  = 10;
		recv_stall_pct = 54;
		line_xor       = '0;
		told_sum       = '0;
		span_state     = SPAN_OUTSIDE;
		kept_len       = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// A full line of separators: the largest number of results one CR can cause
		commas = "";
		repeat (LINE_LIMIT + 1) commas = {commas, ","};
		stim_table.push_back('{{commas, "\r"}, -1, 1'b0, BY_PARSER});

		// Walk the directed table
		foreach (stim_table[r]) begin
			row_bytes = {};
			for (int i = 0; i < stim_table[r].text.len(); i++)
				row_bytes.push_back(stim_table[r].text[i]);
			if (stim_table[r].nul_at >= 0) row_bytes[stim_table[r].nul_at] = 8'h00;
			if (stim_table[r].sealed) seal_line(row_bytes, 1'b1);
			foreach (row_bytes[i]) put_byte(row_bytes[i], stim_table[r].check);
		end

		// Random lines in three pressure phases: receiver-heavy stall, sender-heavy
		// idle, then back to back
		random_base = bytes_taken;
		done        = 0;
		while (done < RANDOM_BYTES) begin
			if (done < RANDOM_BYTES / 3) begin
				send_idle_pct  = 10;
				recv_stall_pct = 54;
			end else if (done < 2 * RANDOM_BYTES / 3) begin
				send_idle_pct  = 54;
				recv_stall_pct = 10;
			end else begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			send_random_sentence();
			done = bytes_taken - random_base;
		end
		in_valid = 1'b0;

		// Drain, then give the block time to show any stray result
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
